/* rtl/kwc_pkg.sv */
package kwc_pkg;

  // Build-time sizes.
  localparam int NUM_KEYWORDS = 15;
  localparam int MAX_WORD_LEN = 100;
  localparam int COUNT_WIDTH  = 16;

  // The keyword table has fifteen entries; only the first ActiveKeys are searched.
  localparam int TABLE_SIZE = 15;
  localparam int ActiveKeys = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;
  localparam int PACK_CHARS = 8;
  localparam int WORD_BITS  = 8 * PACK_CHARS;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = 4;
  localparam int HIT_W      = 16;

  // Keyword text, first character in the low byte, sorted alphabetically.
  localparam logic [WORD_BITS-1:0] KW_CHARS [TABLE_SIZE] = '{
    64'h0000_0000_6F74_7561, // auto
    64'h0000_006B_6165_7262, // break
    64'h0000_0000_6573_6163, // case
    64'h0000_0000_7261_6863, // char
    64'h0000_0074_736E_6F63, // const
    64'h6575_6E69_746E_6F63, // continue
    64'h0074_6C75_6166_6564, // default
    64'h0000_656E_6966_6564, // define
    64'h0000_0074_616F_6C66, // float
    64'h0000_0000_0072_6F66, // for
    64'h0000_0000_0074_6E69, // int
    64'h6465_6E67_6973_6E75, // unsigned
    64'h0000_0000_6469_6F76, // void
    64'h656C_6974_616C_6F76, // volatile
    64'h0000_0065_6C69_6877  // while
  };

  localparam logic [3:0] KW_LEN [TABLE_SIZE] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6,
    4'd5, 4'd3, 4'd3, 4'd8, 4'd4, 4'd8, 4'd5
  };

  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4,
    MODE_HASH       = 3'd5,
    MODE_UNDER      = 3'd6,
    MODE_WORD       = 3'd7
  } scan_mode_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_LOAD = 2'd1,
    ST_EMIT = 2'd2,
    ST_OUT  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } kwc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] keyword_index;
    logic [HIT_W-1:0] hit_count;
    logic             present;
    logic             last;
  } kwc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step_char;
    logic finish_input;
    logic load_pending;
    logic emit;
    logic clear_counts;
  } kwc_cmd_t;

  typedef struct packed {
    logic out_last;
  } kwc_stat_t;

  // Limits a count to the 16-bit report field.
  function automatic logic [HIT_W-1:0] sat_hit(logic [COUNT_WIDTH-1:0] c);
    logic [31:0] v;
    v = 32'(c);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* rtl/keyword_counter_tokenizer.sv */
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_ready_o   kwc_in_t  {ch, end_of_input}
// out       output     out_valid_o / out_ready_i kwc_out_t {keyword_index, hit_count,
//                                                           present, last}
//
// A source byte is taken in every cycle while no report is running, so the text
// streams at one word per cycle. An end-of-input word starts the report sequencer:
// a load state snapshots the nonzero counters, then each reported keyword passes
// through an emit state and an output state that waits for the sink; a report has
// at least one result. Input is not taken during the report.
// Reset is asynchronous and active low; it clears the tokenizer and all counters.
module keyword_counter_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kwc_pkg::kwc_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kwc_pkg::kwc_out_t out_o
);

  // The controller sequences the report and gates the input; the datapath
  // holds the tokenizer, the keyword counters and the output register.
  kwc_pkg::kwc_cmd_t  cmd;
  kwc_pkg::kwc_stat_t stat;

  kwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eoi_i    (in_i.end_of_input),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The byte itself is only looked at when the controller issues a step command.
  kwc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ch_i   (in_i.ch),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

/* rtl/kwc_ctrl.sv */
module kwc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eoi_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kwc_pkg::kwc_stat_t  stat_i,
  output kwc_pkg::kwc_cmd_t   cmd_o
);

  kwc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwc_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kwc_pkg::ST_RUN: begin
        if (in_valid_i && in_eoi_i) begin
          state_d = kwc_pkg::ST_LOAD;
        end
      end
      kwc_pkg::ST_LOAD: state_d = kwc_pkg::ST_EMIT;
      kwc_pkg::ST_EMIT: state_d = kwc_pkg::ST_OUT;
      kwc_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = stat_i.out_last ? kwc_pkg::ST_RUN : kwc_pkg::ST_EMIT;
        end
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      kwc_pkg::ST_RUN: begin
        in_ready_o         = 1'b1;
        cmd_o.step_char    = in_valid_i && !in_eoi_i;
        cmd_o.finish_input = in_valid_i && in_eoi_i;
      end
      kwc_pkg::ST_LOAD: cmd_o.load_pending = 1'b1;
      kwc_pkg::ST_EMIT: cmd_o.emit = 1'b1;
      kwc_pkg::ST_OUT: begin
        out_valid_o        = 1'b1;
        cmd_o.clear_counts = out_ready_i && stat_i.out_last;
      end
    endcase
  end

endmodule

/* rtl/kwc_datapath.sv */
module kwc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         ch_i,
  input  kwc_pkg::kwc_cmd_t  cmd_i,
  output kwc_pkg::kwc_stat_t stat_o,
  output kwc_pkg::kwc_out_t  out_o
);

  localparam int NK = kwc_pkg::ActiveKeys;
  localparam int WB = kwc_pkg::WORD_BITS;
  localparam int LW = kwc_pkg::LEN_W;

  kwc_pkg::scan_mode_e mode_q, mode_d;
  logic [WB-1:0] word_q, word_d;
  logic [LW-1:0] len_q, len_d;
  logic [kwc_pkg::COUNT_WIDTH-1:0] cnt_q [NK];
  logic [NK-1:0] pend_q, pend_d;
  kwc_pkg::kwc_out_t out_q, out_d;

  logic          fin;
  logic [WB-1:0] fin_chars;
  logic [LW-1:0] fin_len;
  logic [WB-1:0] app_word;
  logic [LW-1:0] app_len;
  logic [NK-1:0] match;
  logic [NK-1:0] nz_mask;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic kwc_pkg::scan_mode_e start_mode(logic [7:0] c);
    kwc_pkg::scan_mode_e m;
    priority if (c == 8'h2F) m = kwc_pkg::MODE_SLASH;
    else if (c == 8'h23)     m = kwc_pkg::MODE_HASH;
    else if (c == 8'h5F)     m = kwc_pkg::MODE_UNDER;
    else if (is_alpha(c))    m = kwc_pkg::MODE_WORD;
    else                     m = kwc_pkg::MODE_START;
    return m;
  endfunction

  // Tokenizer next state.
  always_comb begin
    mode_d    = mode_q;
    word_d    = word_q;
    len_d     = len_q;
    fin       = 1'b0;
    fin_chars = word_q;
    fin_len   = len_q;
    app_word  = word_q;
    if (len_q < LW'(kwc_pkg::PACK_CHARS)) begin
      app_word[8*len_q[2:0] +: 8] = ch_i;
    end
    app_len = len_q + 1'b1;

    if (cmd_i.finish_input) begin
      fin    = (mode_q == kwc_pkg::MODE_WORD);
      mode_d = kwc_pkg::MODE_START;
      word_d = '0;
      len_d  = '0;
    end else if (cmd_i.step_char) begin
      unique case (mode_q)
        kwc_pkg::MODE_BLOCK: begin
          if (ch_i == 8'h2A) mode_d = kwc_pkg::MODE_BLOCK_STAR;
        end
        kwc_pkg::MODE_BLOCK_STAR: begin
          if (ch_i == 8'h2F) begin
            mode_d = kwc_pkg::MODE_START;
          end else if (ch_i != 8'h2A) begin
            mode_d = kwc_pkg::MODE_BLOCK;
          end
        end
        kwc_pkg::MODE_LINE, kwc_pkg::MODE_HASH: begin
          if (ch_i == 8'h0A) mode_d = kwc_pkg::MODE_START;
        end
        kwc_pkg::MODE_UNDER: begin
          if (is_space(ch_i)) mode_d = kwc_pkg::MODE_START;
        end
        kwc_pkg::MODE_SLASH: begin
          if (ch_i == 8'h2A) begin
            mode_d = kwc_pkg::MODE_BLOCK;
          end else if (ch_i == 8'h2F) begin
            mode_d = kwc_pkg::MODE_LINE;
          end else begin
            mode_d = start_mode(ch_i);
            word_d = {{(WB-8){1'b0}}, ch_i};
            len_d  = LW'(1);
          end
        end
        kwc_pkg::MODE_WORD: begin
          if (is_alpha(ch_i) || is_digit(ch_i)) begin
            word_d = app_word;
            len_d  = app_len;
            if (app_len >= LW'(kwc_pkg::MAX_WORD_LEN)) begin
              // A word that reaches the length limit ends right here.
              fin       = 1'b1;
              fin_chars = app_word;
              fin_len   = app_len;
              mode_d    = kwc_pkg::MODE_START;
              word_d    = '0;
              len_d     = '0;
            end
          end else begin
            // The terminating byte cannot start a word, so the word clears.
            fin    = 1'b1;
            mode_d = start_mode(ch_i);
            word_d = '0;
            len_d  = '0;
          end
        end
        kwc_pkg::MODE_START: begin
          mode_d = start_mode(ch_i);
          word_d = {{(WB-8){1'b0}}, ch_i};
          len_d  = LW'(1);
        end
      endcase
    end
  end

  // Parallel keyword compare; table entries are distinct, so at most one hits.
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      match[k]   = fin && (fin_len == LW'(kwc_pkg::KW_LEN[k]))
                   && (fin_chars == kwc_pkg::KW_CHARS[k]);
      nz_mask[k] = |cnt_q[k];
    end
  end

  // Report selection: lowest pending keyword first.
  logic [NK-1:0] pick;
  logic [kwc_pkg::IDX_W-1:0] pick_idx;
  logic [kwc_pkg::COUNT_WIDTH-1:0] pick_cnt;

  always_comb begin
    pick     = pend_q & (~pend_q + 1'b1);
    pick_idx = '0;
    pick_cnt = '0;
    for (int k = 0; k < NK; k++) begin
      if (pick[k]) begin
        pick_idx = kwc_pkg::IDX_W'(k);
        pick_cnt = cnt_q[k];
      end
    end
    pend_d = pend_q;
    out_d  = out_q;
    if (cmd_i.load_pending) begin
      pend_d = nz_mask;
    end else if (cmd_i.emit) begin
      pend_d = pend_q & ~pick;
      if (pend_q == '0) begin
        out_d = '{keyword_index: '0, hit_count: '0, present: 1'b0, last: 1'b1};
      end else begin
        out_d.keyword_index = pick_idx;
        out_d.hit_count     = kwc_pkg::sat_hit(pick_cnt);
        out_d.present       = 1'b1;
        out_d.last          = (pend_q & ~pick) == '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kwc_pkg::MODE_START;
      word_q <= '0;
      len_q  <= '0;
      pend_q <= '0;
      for (int k = 0; k < NK; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      mode_q <= mode_d;
      word_q <= word_d;
      len_q  <= len_d;
      pend_q <= pend_d;
      for (int k = 0; k < NK; k++) begin
        if (cmd_i.clear_counts) begin
          cnt_q[k] <= '0;
        end else if (match[k] && !(&cnt_q[k])) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o           = out_q;
  assign stat_o.out_last = out_q.last;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import kwc_pkg::*;

  // Sizes and the bytes that steer the tokenizer.
  localparam int          NUM_KW     = 15;
  localparam int          PACKED_MAX = 8;
  localparam int          WORD_LIMIT = 100;
  localparam logic [15:0] HIT_MAX    = 16'hFFFF;
  localparam logic [7:0]  CH_SLASH   = 8'h2F;
  localparam logic [7:0]  CH_STAR    = 8'h2A;
  localparam logic [7:0]  CH_HASH    = 8'h23;
  localparam logic [7:0]  CH_UNDER   = 8'h5F;
  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam int          MAX_PRINTED = 100;

  // Keeps its own copy of the tokenizer state and keyword counters, and queues
  // the report entries each end-of-input word should produce.
  class keyword_tally;
    scan_mode_e  mode;
    logic [63:0] lead_chars;
    logic [6:0]  word_len;
    logic [15:0] hits [NUM_KW];
    string       spelling [NUM_KW];
    logic [63:0] kw_packed [NUM_KW];
    int          kw_len [NUM_KW];
    kwc_out_t    pending_entries [$];
    int          errors;
    int          chars_in;
    int          ends_in;
    int          entries_ok;

    function new();
      logic [63:0] p;
      spelling = '{"auto", "break", "case", "char", "const", "continue", "default",
                   "define", "float", "for", "int", "unsigned", "void", "volatile",
                   "while"};
      for (int k = 0; k < NUM_KW; k++) begin
        p = '0;
        for (int i = 0; i < spelling[k].len(); i++) p[8*i +: 8] = spelling[k][i];
        kw_packed[k] = p;
        kw_len[k] = spelling[k].len();
      end
      errors = 0;
      chars_in = 0;
      ends_in = 0;
      entries_ok = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_START;
      lead_chars = '0;
      word_len = '0;
      foreach (hits[k]) hits[k] = '0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_alnum(logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9");
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Exact compare against the table; only words of at most eight characters
    // can ever match, since that is all the packed form holds.
    function void close_word();
      bit found;
      found = 1'b0;
      if (word_len >= 1 && word_len <= PACKED_MAX) begin
        for (int k = 0; k < NUM_KW; k++) begin
          if (!found && kw_len[k] == int'(word_len) && kw_packed[k] == lead_chars) begin
            found = 1'b1;
            if (hits[k] != HIT_MAX) hits[k] = hits[k] + 16'd1;
          end
        end
      end
      lead_chars = '0;
      word_len = '0;
      mode = MODE_START;
    endfunction

    function void add_char(logic [7:0] c);
      if (word_len < PACKED_MAX) lead_chars[8*word_len +: 8] = c;
      word_len = word_len + 7'd1;
      if (word_len >= WORD_LIMIT) close_word();
    endfunction

    function void start_token(logic [7:0] c);
      if (c == CH_SLASH) begin
        mode = MODE_SLASH;
      end else if (c == CH_HASH) begin
        mode = MODE_HASH;
      end else if (c == CH_UNDER) begin
        mode = MODE_UNDER;
      end else if (is_letter(c)) begin
        mode = MODE_WORD;
        lead_chars = '0;
        word_len = '0;
        add_char(c);
      end else begin
        mode = MODE_START;
      end
    endfunction

    // Advances the copy by one accepted word; an end-of-input word queues the report.
    function void absorb(kwc_in_t w);
      kwc_out_t e;
      int top;
      if (!w.end_of_input) begin
        chars_in++;
        case (mode)
          MODE_SLASH: begin
            if (w.ch == CH_STAR) mode = MODE_BLOCK;
            else if (w.ch == CH_SLASH) mode = MODE_LINE;
            else start_token(w.ch);
          end
          MODE_BLOCK: begin
            if (w.ch == CH_STAR) mode = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (w.ch == CH_SLASH) mode = MODE_START;
            else if (w.ch != CH_STAR) mode = MODE_BLOCK;
          end
          MODE_LINE, MODE_HASH: begin
            if (w.ch == CH_NL) mode = MODE_START;
          end
          MODE_UNDER: begin
            if (is_blank(w.ch)) mode = MODE_START;
          end
          MODE_WORD: begin
            if (is_alnum(w.ch)) begin
              add_char(w.ch);
            end else begin
              close_word();
              start_token(w.ch);
            end
          end
          default: start_token(w.ch);
        endcase
        return;
      end
      ends_in++;
      if (mode == MODE_WORD) close_word();
      top = -1;
      for (int k = 0; k < NUM_KW; k++) if (hits[k] != '0) top = k;
      if (top < 0) begin
        e.keyword_index = '0;
        e.hit_count = '0;
        e.present = 1'b0;
        e.last = 1'b1;
        pending_entries.push_back(e);
      end else begin
        for (int k = 0; k < NUM_KW; k++) begin
          if (hits[k] != '0) begin
            e.keyword_index = 4'(k);
            e.hit_count = hits[k];
            e.present = 1'b1;
            e.last = (k == top);
            pending_entries.push_back(e);
          end
        end
      end
      clear();
    endfunction

    task report_miss(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("t=%0t mismatch: %s", $time, msg);
    endtask

    task check_entry(kwc_out_t got);
      kwc_out_t want;
      if (pending_entries.size() == 0) begin
        report_miss($sformatf("unexpected entry index %0d count %0d present %b last %b",
                              got.keyword_index, got.hit_count, got.present, got.last));
        return;
      end
      want = pending_entries.pop_front();
      if (got.keyword_index !== want.keyword_index || got.hit_count !== want.hit_count ||
          got.present !== want.present || got.last !== want.last) begin
        report_miss($sformatf({"got index %0d count %0d present %b last %b, ",
                               "expected index %0d count %0d present %b last %b"},
                              got.keyword_index, got.hit_count, got.present, got.last,
                              want.keyword_index, want.hit_count, want.present, want.last));
      end else begin
        entries_ok++;
      end
    endtask

    function int pending();
      return pending_entries.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  kwc_in_t  in_word;
  logic     out_valid;
  logic     out_ready;
  kwc_out_t out_word;

  // Idle percentages for the sending and receiving sides.
  int send_idle;
  int recv_idle;

  keyword_tally tally;
  kwc_in_t      text_q [$];

  keyword_counter_tokenizer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_word)
  );

  always #1 clk = ~clk;

  // A hung handshake ends the run here.
  initial begin
    #3_000_000;
    $display("Run timed out with %0d report entries still outstanding.", tally.pending());
    $display("testbench NOT OK");
    $finish;
  end

  // Receiving side. The ready line is redrawn at every falling edge, and an
  // entry is taken and checked at each rising edge where valid and ready
  // were both high.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tally.check_entry(out_word);
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one word to the block. Entered and left at a falling edge; the
  // idle draw comes before valid rises, so valid never drops while waiting.
  task automatic send_word(kwc_in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (!in_ready);
    tally.absorb(w);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic flush_text();
    foreach (text_q[i]) send_word(text_q[i]);
    text_q.delete();
  endtask

  // Holds the sender back until every queued report entry has come out.
  task automatic drain();
    in_valid = 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] c);
    kwc_in_t w;
    w.ch = c;
    w.end_of_input = 1'b0;
    text_q.push_back(w);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // The character field is ignored on an end-of-input word, so it carries noise.
  function automatic void add_end();
    kwc_in_t w;
    w.ch = 8'($urandom_range(255));
    w.end_of_input = 1'b1;
    text_q.push_back(w);
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(3) != 0) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(48, 57)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  // Bytes that end a word without opening a comment or a skipped run.
  function automatic logic [7:0] rand_sep();
    case ($urandom_range(7))
      0: return CH_SPACE;
      1: return 8'h09;
      2: return CH_NL;
      3: return ";";
      4: return "(";
      5: return ",";
      6: return 8'h0D;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // Appends one piece of C-like text. Keywords dominate so reports are rich;
  // the rest exercises comments, skipped runs, near misses and plain noise.
  function automatic void add_fragment();
    int    pick;
    int    n;
    string kw;
    string punct;
    punct = "+-=<>{}[]!&|~%";
    pick = $urandom_range(99);
    kw = tally.spelling[$urandom_range(NUM_KW - 1)];
    if (pick < 30) begin
      add_text(kw);
      add_byte(rand_sep());
    end else if (pick < 40) begin
      // Plain identifier, mixed case and digits.
      n = $urandom_range(12);
      add_byte(rand_letter());
      repeat (n) add_byte(rand_alnum());
      add_byte(rand_sep());
    end else if (pick < 45) begin
      // Near misses: trailing digit, capital letter, prefix, one letter too many.
      case ($urandom_range(3))
        0: begin
          add_text(kw);
          add_byte(8'($urandom_range(48, 57)));
        end
        1: begin
          add_byte(kw[0] - 8'd32);
          add_text(kw.substr(1, kw.len() - 1));
        end
        2: add_text(kw.substr(0, kw.len() - 2));
        default: begin
          add_text(kw);
          add_byte(rand_letter());
        end
      endcase
      add_byte(rand_sep());
    end else if (pick < 53) begin
      // Block comment, stars and slashes inside, closed by one or more stars.
      add_text("/*");
      n = $urandom_range(10);
      repeat (n) begin
        case ($urandom_range(4))
          0: add_byte(CH_STAR);
          1: add_byte(CH_SLASH);
          2: add_byte(CH_SPACE);
          3: add_text(kw);
          default: add_byte(rand_letter());
        endcase
      end
      add_text(($urandom_range(1) != 0) ? "*/" : "**/");
    end else if (pick < 59) begin
      add_text("//");
      n = $urandom_range(10);
      repeat (n) add_byte(8'($urandom_range(255)));
      add_text(kw);
      add_byte(CH_NL);
    end else if (pick < 64) begin
      add_byte(CH_HASH);
      add_text(($urandom_range(1) != 0) ? "define " : "include ");
      add_text(kw);
      add_byte(CH_NL);
    end else if (pick < 69) begin
      add_byte(CH_UNDER);
      if ($urandom_range(1) != 0) add_text(kw);
      else add_byte(rand_letter());
      add_byte(rand_blank());
    end else if (pick < 74) begin
      // A slash that opens nothing; the next byte must still be seen.
      add_byte(CH_SLASH);
      if ($urandom_range(1) != 0) add_text(kw);
      add_byte(rand_sep());
    end else if (pick < 79) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(2))
          0: add_byte(8'($urandom_range(48, 57)));
          1: add_byte(punct[$urandom_range(punct.len() - 1)]);
          default: add_byte(8'($urandom_range(128, 255)));
        endcase
      end
    end else if (pick < 84) begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(rand_blank());
    end else if (pick < 87) begin
      // Long word around the split point, sometimes glued to a keyword.
      case ($urandom_range(3))
        0: n = WORD_LIMIT - 1;
        1: n = WORD_LIMIT;
        2: n = WORD_LIMIT + 1;
        default: n = $urandom_range(9, 130);
      endcase
      add_byte(rand_letter());
      repeat (n - 1) add_byte(rand_alnum());
      if ($urandom_range(1) != 0) add_text(kw);
      add_byte(rand_sep());
    end else if (pick < 92) begin
      // Comments back to back, then a keyword that must still count.
      add_text(($urandom_range(1) != 0) ? "/**/" : "/*x*/");
      case ($urandom_range(2))
        0: add_text("//c\n");
        1: add_text("/*y**/");
        default: add_text("#z\n");
      endcase
      add_text(kw);
      add_byte(rand_sep());
    end else begin
      add_byte(8'($urandom_range(255)));
    end
  endfunction

  // Leaves the scanner somewhere other than token start when the stream ends.
  function automatic void add_open_tail();
    string kw;
    kw = tally.spelling[$urandom_range(NUM_KW - 1)];
    case ($urandom_range(6))
      0: begin
        add_text("/*");
        add_text(kw);
      end
      1: begin
        add_text("//");
        add_text(kw);
      end
      2: begin
        add_byte(CH_HASH);
        add_text(kw);
      end
      3: begin
        add_byte(CH_UNDER);
        add_text(kw);
      end
      4: add_byte(CH_SLASH);
      5: add_text(kw);
      default: add_text("/*a*");
    endcase
  endfunction

  // One stream of random length ending in end of input, sometimes twice so
  // the second report comes out empty.
  task automatic send_stream();
    int len;
    len = $urandom_range(8, 60);
    while (text_q.size() < len) add_fragment();
    if ($urandom_range(99) < 40) add_open_tail();
    add_end();
    if ($urandom_range(99) < 10) add_end();
    flush_text();
  endtask

  task automatic run_streams(int count);
    int base;
    base = tally.chars_in + tally.ends_in;
    while (tally.chars_in + tally.ends_in - base < count) send_stream();
  endtask

  initial begin
    tally = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    send_idle = 34;
    recv_idle = 87;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed stream: comments back to back with a double-star close, a
    // slash that opens nothing followed by the top byte, a zero byte, a word
    // still open at end of input, then an empty report.
    add_text("int/*a**//**/for/");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_text("while");
    add_end();
    add_end();
    flush_text();

    // Sender idles lightly, receiver heavily, with a full pause midway.
    run_streams(60);
    drain();
    run_streams(60);
    drain();

    // Roles swapped.
    send_idle = 87;
    recv_idle = 34;
    run_streams(120);
    drain();

    // No idling on either side.
    send_idle = 0;
    recv_idle = 0;
    run_streams(120);
    drain();

    // Let any stray entry show up before closing.
    repeat (40) @(posedge clk);
    if (tally.pending() != 0)
      tally.report_miss($sformatf("%0d expected entries never came out", tally.pending()));

    $display("Covered %0d source bytes and %0d end-of-input words under three idle mixes,",
             tally.chars_in, tally.ends_in);
    $display("with %0d report entries matched and the sender held back until reports drained.",
             tally.entries_ok);
    if (tally.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/kwc_pkg.sv
rtl/kwc_ctrl.sv
rtl/kwc_datapath.sv
rtl/keyword_counter_tokenizer.sv
verif/testbench.sv
